// File: hw/rtl/dns_pkg.sv
// Shared types and constants of the dataflow node scheduler.
// Holds the configuration record, the controller states and the
// command and status groups between controller and datapath.
package dns_pkg;

	localparam int NODE_MAX   = 16;
	localparam int CHAN_MAX   = 8;
	localparam int NODE_IDX_W = 4;
	localparam int NODE_CNT_W = 5;
	localparam int CHAN_CNT_W = 4;
	localparam int LEN_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_NUM_NODES     = 3'd0;
	localparam cfg_idx_t REG_NUM_CHANNELS  = 3'd1;
	localparam cfg_idx_t REG_BACKLOG_LIMIT = 3'd2;
	localparam cfg_idx_t REG_CONSUMER_MAP  = 3'd3;
	localparam cfg_idx_t REG_PRODUCER_MAP  = 3'd4;

	localparam logic [NODE_CNT_W-1:0] RST_NUM_NODES     = 5'd16;
	localparam logic [CHAN_CNT_W-1:0] RST_NUM_CHANNELS  = 4'd0;
	localparam logic [LEN_W-1:0]      RST_BACKLOG_LIMIT = 16'd1000;

	typedef struct packed {
		logic [NODE_CNT_W-1:0]           num_nodes;
		logic [CHAN_CNT_W-1:0]           num_channels;
		logic [LEN_W-1:0]                backlog_limit;
		logic [CHAN_MAX*NODE_IDX_W-1:0]  consumer_map;
		logic [CHAN_MAX*NODE_IDX_W-1:0]  producer_map;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIO,
		ST_RR,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_in;
		logic prio_step;
		logic rr_step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic prio_found;
	} dp_status_t;

endpackage

// File: hw/rtl/dns_cfg_regs.sv
// Configuration register file of the dataflow node scheduler.
// Depends on dns_pkg for the register indexes and the cfg_t record.
module dns_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  dns_pkg::cfg_idx_t          cfg_index,
	input  logic [dns_pkg::CFG_DATA_W-1:0] cfg_data,
	output dns_pkg::cfg_t              cfg
);
	import dns_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_nodes     <= RST_NUM_NODES;
			cfg_q.num_channels  <= RST_NUM_CHANNELS;
			cfg_q.backlog_limit <= RST_BACKLOG_LIMIT;
			cfg_q.consumer_map  <= '0;
			cfg_q.producer_map  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_NUM_NODES:     cfg_q.num_nodes     <= cfg_data[NODE_CNT_W-1:0];
				REG_NUM_CHANNELS:  cfg_q.num_channels  <= cfg_data[CHAN_CNT_W-1:0];
				REG_BACKLOG_LIMIT: cfg_q.backlog_limit <= cfg_data[LEN_W-1:0];
				REG_CONSUMER_MAP:  cfg_q.consumer_map  <= cfg_data;
				REG_PRODUCER_MAP:  cfg_q.producer_map  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/dns_ctrl.sv
// Controller of the dataflow node scheduler: sequences one request
// through accept, priority scan, round-robin search (only when the scan finds no pick) and result load.
// Depends on dns_pkg for state, command and status types.
module dns_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  dns_pkg::dp_status_t status,
	output dns_pkg::dp_cmd_t    cmd
);
	import dns_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_PRIO;
				end
			end
			ST_PRIO: begin
				cmd.prio_step = 1'b1;
				// a backlog pick settles the request, skip the search
				state_d       = status.prio_found ? ST_OUT : ST_RR;
			end
			ST_RR: begin
				cmd.rr_step = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: hw/rtl/dns_dp.sv
// Datapath of the dataflow node scheduler: request registers, backlog
// scan, round-robin search, finish bookkeeping and the result register.
// Depends on dns_pkg; driven by dns_ctrl through dp_cmd_t.
module dns_dp #(
	parameter int NODE_COUNT    = 16,
	parameter int CHANNEL_COUNT = 8,
	parameter int LENGTH_BITS   = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dns_pkg::cfg_t                      cfg,
	input  dns_pkg::dp_cmd_t                   cmd,
	output dns_pkg::dp_status_t                status,
	input  logic [dns_pkg::NODE_MAX-1:0]       ready_mask,
	input  logic [dns_pkg::NODE_MAX-1:0]       done_mask,
	input  logic [63:0]                        lengths_low,
	input  logic [63:0]                        lengths_high,
	output logic                               node_found,
	output logic [dns_pkg::NODE_IDX_W-1:0]     picked_node,
	output logic [dns_pkg::NODE_MAX-1:0]       newly_finished,
	output logic [dns_pkg::CHAN_MAX-1:0]       inputs_closed,
	output logic [dns_pkg::CHAN_MAX-1:0]       outputs_closed
);
	import dns_pkg::*;

	localparam logic [LEN_W-1:0] LEN_CAP =
		LEN_W'((33'd1 << LENGTH_BITS) - 33'd1);
	localparam logic [NODE_CNT_W-1:0] NODE_LIM = NODE_CNT_W'(NODE_COUNT);
	localparam logic [CHAN_CNT_W-1:0] CHAN_LIM = CHAN_CNT_W'(CHANNEL_COUNT);

	function automatic logic [NODE_IDX_W-1:0] lowest_node(input logic [NODE_MAX-1:0] v);
		logic [NODE_IDX_W-1:0] idx;
		idx = '0;
		for (int i = NODE_MAX - 1; i >= 0; i--) begin
			if (v[i]) idx = NODE_IDX_W'(i);
		end
		return idx;
	endfunction

	// request registers
	logic [NODE_MAX-1:0] ready_q, done_q;
	logic [LEN_W-1:0]    len_q [CHAN_MAX];

	// scheduler state and working result
	logic [NODE_MAX-1:0]   finished_q;
	logic [NODE_IDX_W-1:0] last_q;
	logic                  res_found_q;
	logic [NODE_IDX_W-1:0] res_pick_q;
	logic [NODE_MAX-1:0]   res_newly_q;

	// result register
	logic                  found_q;
	logic [NODE_IDX_W-1:0] pick_q;
	logic [NODE_MAX-1:0]   newly_q;
	logic [CHAN_MAX-1:0]   inc_q, outc_q;

	logic [NODE_CNT_W-1:0] n_eff;
	logic [CHAN_CNT_W-1:0] nc_eff;
	logic [NODE_IDX_W-1:0] cons [CHAN_MAX];
	logic [NODE_IDX_W-1:0] prod [CHAN_MAX];
	logic [2*64-1:0]       len_all;
	logic [LEN_W-1:0]      len_raw [CHAN_MAX];

	always_comb begin
		n_eff = cfg.num_nodes;
		if (n_eff == '0) n_eff = NODE_CNT_W'(1);
		if (n_eff > NODE_LIM) n_eff = NODE_LIM;
		nc_eff = (cfg.num_channels > CHAN_LIM) ? CHAN_LIM : cfg.num_channels;
		len_all = {lengths_high, lengths_low};
		for (int j = 0; j < CHAN_MAX; j++) begin
			cons[j]    = cfg.consumer_map[j*NODE_IDX_W +: NODE_IDX_W];
			prod[j]    = cfg.producer_map[j*NODE_IDX_W +: NODE_IDX_W];
			len_raw[j] = len_all[j*LEN_W +: LEN_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ready_q <= ready_mask;
			done_q  <= done_mask;
			for (int j = 0; j < CHAN_MAX; j++) begin
				len_q[j] <= (len_raw[j] > LEN_CAP) ? LEN_CAP : len_raw[j];
			end
		end
	end

	// backlog scan: walk channels in order, finishing done consumers
	logic [CHAN_MAX-1:0]   hit;
	logic                  p_found;
	logic [NODE_IDX_W-1:0] p_pick;
	logic [NODE_MAX-1:0]   p_fin;

	always_comb begin
		p_found = 1'b0;
		p_pick  = '0;
		p_fin   = '0;
		for (int j = 0; j < CHAN_MAX; j++) begin
			hit[j] = (CHAN_CNT_W'(j) < nc_eff) && ({1'b0, cons[j]} < n_eff)
				&& !finished_q[cons[j]] && (len_q[j] > cfg.backlog_limit)
				&& ready_q[cons[j]];
		end
		for (int j = 0; j < CHAN_MAX; j++) begin
			if (!p_found && hit[j]) begin
				if (done_q[cons[j]]) begin
					p_fin[cons[j]] = 1'b1;
				end else begin
					p_found = 1'b1;
					p_pick  = cons[j];
				end
			end
		end
	end

	assign status.prio_found = p_found;

	// round-robin search: upper segment from start, then wrap to node 0
	logic [NODE_MAX-1:0]   fin_now, node_ok, upper, cand, cand_up, cand_lo;
	logic [NODE_MAX-1:0]   ahead, rr_fin;
	logic [NODE_IDX_W-1:0] last_eff, rr_pick;
	logic [NODE_CNT_W-1:0] start_inc, start;
	logic                  rr_found, pick_up;

	always_comb begin
		fin_now   = finished_q | res_newly_q;
		last_eff  = ({1'b0, last_q} < n_eff) ? last_q : NODE_IDX_W'(n_eff - 1'b1);
		start_inc = {1'b0, last_eff} + 1'b1;
		start     = (start_inc == n_eff) ? '0 : start_inc;
		for (int i = 0; i < NODE_MAX; i++) begin
			node_ok[i] = NODE_CNT_W'(i) < n_eff;
			upper[i]   = NODE_CNT_W'(i) >= start;
		end
		cand    = node_ok & ~fin_now & ~done_q & ready_q;
		cand_up = cand & upper;
		cand_lo = cand & ~upper;
		pick_up  = |cand_up;
		rr_found = |cand;
		rr_pick  = pick_up ? lowest_node(cand_up) : lowest_node(cand_lo);
		for (int i = 0; i < NODE_MAX; i++) begin
			if (!rr_found) begin
				ahead[i] = 1'b1;
			end else if (pick_up) begin
				ahead[i] = upper[i] && (NODE_IDX_W'(i) < rr_pick);
			end else begin
				ahead[i] = upper[i] || (NODE_IDX_W'(i) < rr_pick);
			end
		end
		rr_fin = node_ok & ~fin_now & done_q & ahead;
	end

	always_ff @(posedge clk) begin
		if (cmd.prio_step) begin
			res_found_q <= p_found;
			res_pick_q  <= p_pick;
			res_newly_q <= p_fin;
		end else if (cmd.rr_step) begin
			res_found_q <= rr_found;
			res_pick_q  <= rr_found ? rr_pick : '0;
			res_newly_q <= res_newly_q | rr_fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= '0;
			finished_q <= '0;
		end else begin
			if (cmd.rr_step && rr_found) last_q <= rr_pick;
			if (cmd.load_out) finished_q <= finished_q | res_newly_q;
		end
	end

	// close channels whose consumer or producer finished in this request
	logic [CHAN_MAX-1:0] inc_d, outc_d;

	always_comb begin
		for (int j = 0; j < CHAN_MAX; j++) begin
			inc_d[j]  = (CHAN_CNT_W'(j) < nc_eff) && res_newly_q[cons[j]];
			outc_d[j] = (CHAN_CNT_W'(j) < nc_eff) && res_newly_q[prod[j]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			found_q <= res_found_q;
			pick_q  <= res_pick_q;
			newly_q <= res_newly_q;
			inc_q   <= inc_d;
			outc_q  <= outc_d;
		end
	end

	assign node_found     = found_q;
	assign picked_node    = pick_q;
	assign newly_finished = newly_q;
	assign inputs_closed  = inc_q;
	assign outputs_closed = outc_q;

endmodule

// File: hw/rtl/dataflow_node_scheduler.sv
// Top level of the dataflow node scheduler: backlog-priority and
// round-robin node picker. Depends on dns_pkg, dns_cfg_regs, dns_ctrl, dns_dp.
//
//  channel   handshake              payload
//  input     in_valid / in_stall    ready_mask, done_mask, lengths_low, lengths_high
//  output    out_valid / out_stall  node_found, picked_node, newly_finished,
//                                   inputs_closed, outputs_closed
//  config    cfg_wr_en              cfg_index, cfg_data
//
// A request runs through accept, channel scan, search and result load; the
// search is skipped when a backlogged channel yields a pick.
// The controller handles one request at a time; the next beat is taken once
// the result is in the output register, which holds it while out_stall is high.
// Reset clears the finished flags and the round-robin pointer and loads the
// register defaults.
module dataflow_node_scheduler #(
	parameter int NODE_COUNT    = 16,
	parameter int CHANNEL_COUNT = 8,
	parameter int LENGTH_BITS   = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [dns_pkg::NODE_MAX-1:0]       ready_mask,
	input  logic [dns_pkg::NODE_MAX-1:0]       done_mask,
	input  logic [63:0]                        lengths_low,
	input  logic [63:0]                        lengths_high,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               node_found,
	output logic [dns_pkg::NODE_IDX_W-1:0]     picked_node,
	output logic [dns_pkg::NODE_MAX-1:0]       newly_finished,
	output logic [dns_pkg::CHAN_MAX-1:0]       inputs_closed,
	output logic [dns_pkg::CHAN_MAX-1:0]       outputs_closed,
	input  logic                               cfg_wr_en,
	input  dns_pkg::cfg_idx_t                  cfg_index,
	input  logic [dns_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import dns_pkg::*;

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	dns_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dns_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	dns_dp #(
		.NODE_COUNT    (NODE_COUNT),
		.CHANNEL_COUNT (CHANNEL_COUNT),
		.LENGTH_BITS   (LENGTH_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.status         (status),
		.ready_mask     (ready_mask),
		.done_mask      (done_mask),
		.lengths_low    (lengths_low),
		.lengths_high   (lengths_high),
		.node_found     (node_found),
		.picked_node    (picked_node),
		.newly_finished (newly_finished),
		.inputs_closed  (inputs_closed),
		.outputs_closed (outputs_closed)
	);

endmodule
